@@ hw/rtl/compare_rate_channel_controller_top_macros.svh @@
// ----------------------------------------------------------------------------
// compare rate channel controller assertion macros
// shared concurrent assertion forms for the rtl files
// ----------------------------------------------------------------------------
`ifndef COMPARE_RATE_CHANNEL_CONTROLLER_TOP_MACROS_SVH
`define COMPARE_RATE_CHANNEL_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define CRCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crcc assertion failed");

// next-cycle implication, off during reset
`define CRCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crcc assertion failed");

`endif

@@ hw/rtl/crcc_pkg.sv @@
// ----------------------------------------------------------------------------
// crcc_pkg
// widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package crcc_pkg;

  localparam int TICK_W    = 29;
  localparam int RATE_W    = 32;
  localparam int CH_W      = 4;
  localparam int MODE_W    = 2;
  localparam int CMD_W     = 2;
  localparam int HP_W      = 32;
  localparam int NUM_W     = 39;
  localparam int DEN_W     = 33;
  localparam int REM_W     = 34;
  localparam int DIV_STEPS = 39;
  localparam int DCNT_W    = 6;

  localparam logic [9:0] TICK_SCALE = 10'd1000;

  localparam logic [MODE_W-1:0] MODE_SET_RATE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIS_ONE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIS_ALL  = 2'd2;

  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPLY   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENABLE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd3;

  localparam logic [1:0] CHSEL_ZERO  = 2'd0;
  localparam logic [1:0] CHSEL_REQ   = 2'd1;
  localparam logic [1:0] CHSEL_SWEEP = 2'd2;

  typedef struct packed {
    logic             load;
    logic             num_load;
    logic             div_step;
    logic             emit;
    logic [CMD_W-1:0] res_cmd;
    logic [1:0]       ch_sel;
    logic             acc;
    logic             last;
  } crcc_cmd_t;

  typedef struct packed {
    logic              slot_free;
    logic [MODE_W-1:0] mode;
    logic              axis_ok;
    logic              fault;
    logic              rate_zero;
    logic              rate_over;
    logic              div_done;
    logic              hp_bad;
    logic              apply_ok;
    logic              axis_en;
    logic              sweep_last;
  } crcc_sts_t;

endpackage

@@ hw/rtl/crcc_datapath.sv @@
// ----------------------------------------------------------------------------
// crcc_datapath
// request latch, half-period divider, axis flags and result register
// ----------------------------------------------------------------------------
`include "compare_rate_channel_controller_top_macros.svh"

module crcc_datapath
  import crcc_pkg::*;
#(
  parameter int              AXIS_COUNT       = 4,
  parameter logic [RATE_W-1:0] MAX_RATE_MILLIHZ = 32'd100000000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CH_W-1:0]   in_axis,
  input  logic [RATE_W-1:0] in_rate_millihz,
  input  logic              in_apply_ok,
  input  logic [TICK_W-1:0] tick_rate_hz,
  input  crcc_cmd_t         cmd,
  output crcc_sts_t         sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CMD_W-1:0]  out_command,
  output logic [CH_W-1:0]   out_channel,
  output logic [HP_W-1:0]   out_half_ticks,
  output logic              out_accepted,
  output logic              out_last
);

  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  logic [MODE_W-1:0]     mode_r;
  logic [CH_W-1:0]       axis_r;
  logic [RATE_W-1:0]     rate_r;
  logic                  ok_r;
  logic                  fault_r, fault_nxt;
  logic [AXIS_COUNT-1:0] en_r, en_nxt;
  logic [AW-1:0]         sweep_cnt_r, sweep_cnt_nxt;
  logic [NUM_W-1:0]      quo_r;
  logic [REM_W-1:0]      rem_r;
  logic [DEN_W-1:0]      den_r;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CMD_W-1:0]      out_command_r;
  logic [CH_W-1:0]       out_channel_r;
  logic [HP_W-1:0]       out_half_ticks_r;
  logic                  out_accepted_r;
  logic                  out_last_r;

  logic [NUM_W-1:0] num_sum;
  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] diff;
  logic             q_bit;
  logic [AW-1:0]    idx;
  logic [CH_W-1:0]  res_ch;
  logic             axis_ok;
  logic             slot_free;

  // tick*1000 + rate fits in 39 bits
  assign num_sum = NUM_W'(tick_rate_hz) * NUM_W'(TICK_SCALE) + NUM_W'(rate_r);

  // restoring divider, one quotient bit per step
  assign shifted = {rem_r[REM_W-2:0], quo_r[NUM_W-1]};
  assign diff    = shifted - REM_W'(den_r);
  assign q_bit   = !diff[REM_W-1];

  assign axis_ok   = {1'b0, axis_r} < (CH_W+1)'(AXIS_COUNT);
  assign slot_free = !out_valid_r || !out_stall;
  assign idx       = (cmd.ch_sel == CHSEL_SWEEP) ? sweep_cnt_r : axis_r[AW-1:0];

  always_comb begin
    case (cmd.ch_sel)
      CHSEL_REQ:   res_ch = axis_r;
      CHSEL_SWEEP: res_ch = CH_W'(sweep_cnt_r);
      default:     res_ch = '0;
    endcase
  end

  always_comb begin
    en_nxt        = en_r;
    fault_nxt     = fault_r;
    sweep_cnt_nxt = sweep_cnt_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      if (cmd.res_cmd == CMD_DISABLE) begin
        en_nxt[idx] = 1'b0;
      end
      if (cmd.res_cmd == CMD_ENABLE) begin
        en_nxt[idx] = 1'b1;
      end
      if (cmd.res_cmd == CMD_APPLY && !ok_r) begin
        fault_nxt = 1'b1;
      end
      if (cmd.ch_sel == CHSEL_SWEEP) begin
        sweep_cnt_nxt = sweep_cnt_r + AW'(1);
      end
    end
    if (cmd.load) begin
      sweep_cnt_nxt = '0;
    end
    if (cmd.num_load) begin
      dcnt_nxt = '0;
    end else if (cmd.div_step) begin
      dcnt_nxt = dcnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r     <= 1'b0;
      en_r        <= '0;
      sweep_cnt_r <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fault_r     <= fault_nxt;
      en_r        <= en_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      axis_r <= in_axis;
      rate_r <= in_rate_millihz;
      ok_r   <= in_apply_ok;
    end
    if (cmd.num_load) begin
      quo_r <= num_sum;
      rem_r <= '0;
      den_r <= {rate_r, 1'b0};
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUM_W-2:0], q_bit};
      rem_r <= q_bit ? diff : shifted;
    end
    if (cmd.emit) begin
      out_command_r    <= cmd.res_cmd;
      out_channel_r    <= res_ch;
      out_half_ticks_r <= (cmd.res_cmd == CMD_APPLY) ? quo_r[HP_W-1:0] : '0;
      out_accepted_r   <= cmd.acc;
      out_last_r       <= cmd.last;
    end
  end

  always_comb begin
    sts.slot_free  = slot_free;
    sts.mode       = mode_r;
    sts.axis_ok    = axis_ok;
    sts.fault      = fault_r;
    sts.rate_zero  = (rate_r == '0);
    sts.rate_over  = (rate_r > MAX_RATE_MILLIHZ);
    sts.div_done   = (dcnt_r == DCNT_W'(DIV_STEPS));
    sts.hp_bad     = (quo_r == '0) || (|quo_r[NUM_W-1:HP_W]);
    sts.apply_ok   = ok_r;
    sts.axis_en    = axis_ok && en_r[axis_r[AW-1:0]];
    sts.sweep_last = (sweep_cnt_r == AW'(AXIS_COUNT - 1));
  end

  assign out_valid      = out_valid_r;
  assign out_command    = out_command_r;
  assign out_channel    = out_channel_r;
  assign out_half_ticks = out_half_ticks_r;
  assign out_accepted   = out_accepted_r;
  assign out_last       = out_last_r;

  `CRCC_ASSERT_IMP(a_emit_slot_free, clk, rst_n, cmd.emit, slot_free)
  `CRCC_ASSERT_IMP(a_rem_below_den, clk, rst_n, dcnt_r != '0, rem_r < REM_W'(den_r))
  `CRCC_ASSERT_IMP(a_acc_on_last, clk, rst_n, cmd.emit && cmd.acc, cmd.last)
  `CRCC_ASSERT_IMP(a_no_apply_after_fault, clk, rst_n, fault_r, !(cmd.emit && cmd.res_cmd == CMD_APPLY))
  `CRCC_ASSERT_NEXT(a_refusal_latches, clk, rst_n, cmd.emit && cmd.res_cmd == CMD_APPLY && !ok_r, fault_r && sweep_cnt_r == '0)

endmodule

@@ hw/rtl/crcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// crcc_ctrl
// request sequencer: decode, divide, check and emit results one by one
// ----------------------------------------------------------------------------
module crcc_ctrl
  import crcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  crcc_sts_t sts,
  output crcc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_DIV     = 4'd3;
  localparam logic [3:0] S_CHECK   = 4'd4;
  localparam logic [3:0] S_APPLY   = 4'd5;
  localparam logic [3:0] S_ENABLE  = 4'd6;
  localparam logic [3:0] S_SWEEP   = 4'd7;
  localparam logic [3:0] S_DIS_ONE = 4'd8;
  localparam logic [3:0] S_REJECT  = 4'd9;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.mode)
          MODE_DIS_ALL: state_nxt = S_SWEEP;
          MODE_DIS_ONE: state_nxt = sts.axis_ok ? S_DIS_ONE : S_REJECT;
          MODE_SET_RATE: begin
            if (!sts.axis_ok || sts.fault) begin
              state_nxt = S_REJECT;
            end else if (sts.rate_zero) begin
              state_nxt = S_DIS_ONE;
            end else if (sts.rate_over) begin
              state_nxt = S_REJECT;
            end else begin
              state_nxt = S_MUL;
            end
          end
          default: state_nxt = S_REJECT;
        endcase
      end
      S_MUL: begin
        cmd.num_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_CHECK;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_CHECK: begin
        state_nxt = sts.hp_bad ? S_REJECT : S_APPLY;
      end
      S_APPLY: begin
        cmd.emit    = sts.slot_free;
        cmd.res_cmd = CMD_APPLY;
        cmd.ch_sel  = CHSEL_REQ;
        cmd.acc     = sts.apply_ok && sts.axis_en;
        cmd.last    = sts.apply_ok && sts.axis_en;
        if (sts.slot_free) begin
          if (!sts.apply_ok) begin
            state_nxt = S_SWEEP;
          end else if (sts.axis_en) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ENABLE;
          end
        end
      end
      S_ENABLE: begin
        cmd.emit    = sts.slot_free;
        cmd.res_cmd = CMD_ENABLE;
        cmd.ch_sel  = CHSEL_REQ;
        cmd.acc     = 1'b1;
        cmd.last    = 1'b1;
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        // accepted only for a disable-all request, not after a refusal
        cmd.emit    = sts.slot_free;
        cmd.res_cmd = CMD_DISABLE;
        cmd.ch_sel  = CHSEL_SWEEP;
        cmd.acc     = sts.sweep_last && (sts.mode == MODE_DIS_ALL);
        cmd.last    = sts.sweep_last;
        if (sts.slot_free && sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIS_ONE: begin
        cmd.emit    = sts.slot_free;
        cmd.res_cmd = CMD_DISABLE;
        cmd.ch_sel  = CHSEL_REQ;
        cmd.acc     = 1'b1;
        cmd.last    = 1'b1;
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_REJECT: begin
        cmd.emit    = sts.slot_free;
        cmd.res_cmd = CMD_NONE;
        cmd.ch_sel  = CHSEL_ZERO;
        cmd.acc     = 1'b0;
        cmd.last    = 1'b1;
        if (sts.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ hw/rtl/compare_rate_channel_controller_top.sv @@
// ----------------------------------------------------------------------------
// compare_rate_channel_controller_top
// output-compare rate controller: set rate, disable one, disable all axes
// usage:
//   input channel (in_valid/in_stall) takes one item: mode, axis, rate in
//   millihertz and the apply acknowledge of the compare hardware.
//   result channel (out_valid/out_stall) gives one to AXIS_COUNT+1 commands
//   per item; out_last marks the final one, out_accepted can be set only there.
//   set rate: accept, decode, setup, the one-bit-per-cycle restoring divider
//   and range check, then one result per cycle while the receiver does not
//   stall. disable and reject items: accept and decode, then one result per
//   cycle while the receiver does not stall.
//   one item is in work at a time; in_stall is low only when idle, and
//   the registered result lets the next item enter while the last
//   result still waits. a stalled receiver holds the result register and
//   keeps the sequencer in its result states. reset: tick rate 1000000 hz,
//   fault clear, every axis disabled. apb register at byte 0: tick_rate_hz
//   (29 bits); the user writes it only while idle; not enforced by the block.
// ----------------------------------------------------------------------------
module compare_rate_channel_controller_top
  import crcc_pkg::*;
#(
  parameter int                AXIS_COUNT       = 4,
  parameter logic [RATE_W-1:0] MAX_RATE_MILLIHZ = 32'd100000000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [CH_W-1:0]   in_axis,
  input  logic [RATE_W-1:0] in_rate_millihz,
  input  logic              in_apply_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CMD_W-1:0]  out_command,
  output logic [CH_W-1:0]   out_channel,
  output logic [HP_W-1:0]   out_half_ticks,
  output logic              out_accepted,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [TICK_W-1:0] tick_r;
  crcc_cmd_t         cmd;
  crcc_sts_t         sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_W'(1000000);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      tick_r <= pwdata[TICK_W-1:0];
    end
  end

  assign prdata = paddr[2] ? '0 : 32'(tick_r);

  crcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  crcc_datapath #(
    .AXIS_COUNT       (AXIS_COUNT),
    .MAX_RATE_MILLIHZ (MAX_RATE_MILLIHZ)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_axis         (in_axis),
    .in_rate_millihz (in_rate_millihz),
    .in_apply_ok     (in_apply_ok),
    .tick_rate_hz    (tick_r),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_command     (out_command),
    .out_channel     (out_channel),
    .out_half_ticks  (out_half_ticks),
    .out_accepted    (out_accepted),
    .out_last        (out_last)
  );

endmodule
